// File: rtl/glmd_pkg.sv
// Shared types, constants and helper functions for the grid local minimum detector.
// No dependencies; every other file but glmd_ram refers to this package by scoped names.
package glmd_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int MAX_COLS       = 1024;
    localparam int MAX_ROWS       = 1024;
    localparam int COL_BITS       = $clog2(MAX_COLS);
    localparam int ROW_BITS       = $clog2(MAX_ROWS);
    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_INDEX_BITS = 2;
    localparam int OUT_ROW_BITS   = 10;
    localparam int OUT_COL_BITS   = 10;
    localparam int OUT_FIELD_BITS = OUT_ROW_BITS + OUT_COL_BITS + 1;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int NUM_SLOTS      = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1
    } cfg_reg_t;

    // Decision slots in emission order, relative to the arriving cell (r,c).
    // bit 1 selects row r (else r-1), bit 0 selects column c (else c-1).
    typedef enum logic [1:0] {
        SLOT_ABOVE_LEFT = 2'd0,
        SLOT_ABOVE      = 2'd1,
        SLOT_LEFT       = 2'd2,
        SLOT_CENTER     = 2'd3
    } slot_t;

    typedef logic signed [VALUE_BITS-1:0] val_t;

    // win[row][col]: rows r-2, r-1, r; cols c-2, c-1, c; index 3 is padding.
    typedef val_t [3:0][3:0] win_t;

    typedef struct packed {
        logic                valid;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic [NUM_SLOTS-1:0] mask;
    } stage_info_t;

    function automatic logic [COL_BITS-1:0] last_col_of(input logic [CFG_DATA_BITS-1:0] v);
        logic [COL_BITS-1:0] res;
        if (v <= CFG_DATA_BITS'(1)) begin
            res = '0;
        end else if (int'(v) > MAX_COLS) begin
            res = COL_BITS'(MAX_COLS - 1);
        end else begin
            res = COL_BITS'(v - CFG_DATA_BITS'(1));
        end
        return res;
    endfunction

    function automatic logic [ROW_BITS-1:0] last_row_of(input logic [CFG_DATA_BITS-1:0] v);
        logic [ROW_BITS-1:0] res;
        if (v <= CFG_DATA_BITS'(1)) begin
            res = '0;
        end else if (int'(v) > MAX_ROWS) begin
            res = ROW_BITS'(MAX_ROWS - 1);
        end else begin
            res = ROW_BITS'(v - CFG_DATA_BITS'(1));
        end
        return res;
    endfunction

    // 3x3 minimum test around the selected center. Excluded neighbors are
    // those outside the matrix: top/left from flags, bottom/right whenever
    // the center sits on the arriving row/column (those are always edges).
    function automatic logic decide_min(input win_t win, input logic dr_sel,
                                        input logic dc_sel, input logic top_excl,
                                        input logic left_excl);
        logic [1:0] cr;
        logic [1:0] cc;
        logic [1:0] nr;
        logic [1:0] nc;
        val_t       center;
        val_t       nb;
        logic       skip;
        logic       res;
        cr     = {1'b0, dr_sel} + 2'd1;
        cc     = {1'b0, dc_sel} + 2'd1;
        center = win[cr][cc];
        res    = ~center[VALUE_BITS-1];
        for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
                nr   = {1'b0, dr_sel} + 2'(dy);
                nc   = {1'b0, dc_sel} + 2'(dx);
                nb   = win[nr][nc];
                skip = (dy == 1 && dx == 1) || (dy == 0 && top_excl) ||
                       (dy == 2 && dr_sel) || (dx == 0 && left_excl) ||
                       (dx == 2 && dc_sel);
                if (!skip && ($signed(center) > $signed(nb))) begin
                    res = 1'b0;
                end
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/grid_local_minimum_detector_unit.sv
// An accepted cell's first decision enters the output register once that is free. Throughput:
// one cell per cycle while m_tready is high and no cell has over one decision; a cell with k
// decisions holds the window stage until the last is loaded (up to two at a row end and on
// the bottom row, four at bottom-right); the single output register takes one word per cycle.
// Reset (aresetn low, synchronous): counters to zero, sizes to 1024, stages empty.
// The row stores are not cleared; no clearing pass, cells are accepted right away.
module grid_local_minimum_detector_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration: index 0 grid_width, index 1 grid_height; other indexes ignored
    input  logic                                cfg_wr_en,
    input  logic [glmd_pkg::CFG_INDEX_BITS-1:0] cfg_wr_index,
    input  logic [glmd_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
    // cell stream, raster order
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [glmd_pkg::VALUE_BITS-1:0]     s_tdata,   // [31:0] cell_value
    // decision stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [glmd_pkg::OUT_TDATA_BITS-1:0] m_tdata,   // [9:0] cell_row, [19:10] cell_col,
                                                           // [20] is_minimum, [23:21] zero
    output logic                                m_tlast,   // run_last
    output logic                                m_tuser    // [0] matrix_done
);

    // Datapath: the accepted word, the two row-store reads at the same column
    // and six history registers form a 3x3 window (rows r-2..r, cols c-2..c).
    // Every decision the arriving cell completes lies inside that window; the
    // emitter runs them through one comparator set in raster order.
    glmd_pkg::stage_info_t stage;
    glmd_pkg::win_t        win;
    logic                  stage_release;

    glmd_linebuf u_linebuf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .release_i    (stage_release),
        .stage_o      (stage),
        .win_o        (win)
    );

    // stage frees once its last decision is loaded (or at once with none),
    // so a new word enters while the previous result waits downstream
    glmd_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stage_i   (stage),
        .win_i     (win),
        .release_o (stage_release),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// File: rtl/glmd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read-first on an address collision. No dependencies.
module glmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/glmd_linebuf.sv
// Raster counters, size registers, two row stores and the 3x3 window stage.
// Depends on glmd_pkg and glmd_ram.
module glmd_linebuf (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [glmd_pkg::CFG_INDEX_BITS-1:0]  cfg_wr_index,
    input  logic [glmd_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [glmd_pkg::VALUE_BITS-1:0]      s_tdata,
    input  logic                                 release_i,
    output glmd_pkg::stage_info_t                stage_o,
    output glmd_pkg::win_t                       win_o
);

    logic [glmd_pkg::COL_BITS-1:0] col_reg, col_next;
    logic [glmd_pkg::ROW_BITS-1:0] row_reg, row_next;
    logic [glmd_pkg::COL_BITS-1:0] wlast_reg, wlast_next;
    logic [glmd_pkg::ROW_BITS-1:0] hlast_reg, hlast_next;
    logic                          bank_reg, bank_next;
    logic                          stage_valid_reg, stage_valid_next;
    logic [glmd_pkg::ROW_BITS-1:0] stage_row_reg;
    logic [glmd_pkg::COL_BITS-1:0] stage_col_reg;
    logic [glmd_pkg::NUM_SLOTS-1:0] stage_mask_reg;
    logic                          stage_bank_reg;
    glmd_pkg::val_t                cur_reg;
    glmd_pkg::val_t                hist_reg [2][3];   // [col c-2, c-1][row r-2, r-1, r]

    logic                          accept;
    logic                          is_last_col;
    logic                          is_last_row;
    logic                          cfg_hit;
    logic [glmd_pkg::NUM_SLOTS-1:0] mask_new;
    glmd_pkg::val_t                rd0, rd1;
    glmd_pkg::val_t                older_rd, newer_rd;

    assign s_tready    = !stage_valid_reg || release_i;
    assign accept      = s_tvalid && s_tready;
    assign is_last_col = (col_reg == wlast_reg);
    assign is_last_row = (row_reg == hlast_reg);

    // slots: above-left, above, left, center
    assign mask_new = {is_last_row && is_last_col,
                       is_last_row && (col_reg != '0),
                       (row_reg != '0) && is_last_col,
                       (row_reg != '0) && (col_reg != '0)};

    always_comb begin
        wlast_next = wlast_reg;
        hlast_next = hlast_reg;
        cfg_hit    = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                glmd_pkg::REG_GRID_WIDTH: begin
                    wlast_next = glmd_pkg::last_col_of(cfg_wr_data);
                    cfg_hit    = 1'b1;
                end
                glmd_pkg::REG_GRID_HEIGHT: begin
                    hlast_next = glmd_pkg::last_row_of(cfg_wr_data);
                    cfg_hit    = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        bank_next = bank_reg;
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (is_last_col) begin
                col_next  = '0;
                row_next  = is_last_row ? '0 : row_reg + glmd_pkg::ROW_BITS'(1);
                bank_next = !bank_reg;
            end else begin
                col_next = col_reg + glmd_pkg::COL_BITS'(1);
            end
        end
    end

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (accept) begin
            stage_valid_next = 1'b1;
        end else if (release_i) begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg         <= '0;
            row_reg         <= '0;
            wlast_reg       <= glmd_pkg::COL_BITS'(glmd_pkg::MAX_COLS - 1);
            hlast_reg       <= glmd_pkg::ROW_BITS'(glmd_pkg::MAX_ROWS - 1);
            bank_reg        <= 1'b0;
            stage_valid_reg <= 1'b0;
        end else begin
            col_reg         <= col_next;
            row_reg         <= row_next;
            wlast_reg       <= wlast_next;
            hlast_reg       <= hlast_next;
            bank_reg        <= bank_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    // stage payload and column history; shifts once per accepted word
    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_row_reg  <= row_reg;
            stage_col_reg  <= col_reg;
            stage_mask_reg <= mask_new;
            stage_bank_reg <= bank_reg;
            cur_reg        <= s_tdata;
            hist_reg[0]    <= hist_reg[1];
            hist_reg[1][0] <= older_rd;
            hist_reg[1][1] <= newer_rd;
            hist_reg[1][2] <= cur_reg;
        end
    end

    // bank 0 holds the older row while bank_reg is low; the older store
    // takes the arriving row at the column being read (read-first)
    glmd_ram #(.WIDTH(glmd_pkg::VALUE_BITS), .DEPTH(glmd_pkg::MAX_COLS)) u_row0 (
        .aclk    (aclk),
        .wr_en   (accept && !bank_reg),
        .wr_addr (col_reg),
        .wr_data (s_tdata),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd0)
    );

    glmd_ram #(.WIDTH(glmd_pkg::VALUE_BITS), .DEPTH(glmd_pkg::MAX_COLS)) u_row1 (
        .aclk    (aclk),
        .wr_en   (accept && bank_reg),
        .wr_addr (col_reg),
        .wr_data (s_tdata),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd1)
    );

    assign older_rd = stage_bank_reg ? rd1 : rd0;
    assign newer_rd = stage_bank_reg ? rd0 : rd1;

    always_comb begin
        win_o       = '0;
        win_o[0][0] = hist_reg[0][0];
        win_o[1][0] = hist_reg[0][1];
        win_o[2][0] = hist_reg[0][2];
        win_o[0][1] = hist_reg[1][0];
        win_o[1][1] = hist_reg[1][1];
        win_o[2][1] = hist_reg[1][2];
        win_o[0][2] = older_rd;
        win_o[1][2] = newer_rd;
        win_o[2][2] = cur_reg;
    end

    assign stage_o = '{valid: stage_valid_reg, row: stage_row_reg,
                       col: stage_col_reg, mask: stage_mask_reg};

endmodule

// File: rtl/glmd_emit.sv
// Walks a staged cell's decisions into the output register, one per cycle if it is free.
// Depends on glmd_pkg.
module glmd_emit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  glmd_pkg::stage_info_t               stage_i,
    input  glmd_pkg::win_t                      win_i,
    output logic                                release_o,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [glmd_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    output logic                                m_tlast,
    output logic                                m_tuser
);

    logic [glmd_pkg::NUM_SLOTS-1:0]     done_reg, done_next;
    logic                               m_valid_reg, m_valid_next;
    logic [glmd_pkg::OUT_TDATA_BITS-1:0] m_data_reg;
    logic                               m_last_reg;
    logic                               m_user_reg;

    logic [glmd_pkg::NUM_SLOTS-1:0]     remaining;
    logic [glmd_pkg::NUM_SLOTS-1:0]     sel_bit;
    glmd_pkg::slot_t                    sel;
    logic                               single;
    logic                               out_free;
    logic                               push;
    logic                               dr_sel, dc_sel;
    logic                               top_excl, left_excl;
    logic                               is_min;
    logic [glmd_pkg::ROW_BITS-1:0]      res_row;
    logic [glmd_pkg::COL_BITS-1:0]      res_col;

    assign remaining = stage_i.mask & ~done_reg;
    assign single    = ((remaining & (remaining - glmd_pkg::NUM_SLOTS'(1))) == '0);
    assign out_free  = !m_valid_reg || m_tready;
    assign push      = stage_i.valid && (remaining != '0) && out_free;
    assign release_o = stage_i.valid && ((remaining == '0) || (push && single));

    always_comb begin
        if (remaining[0]) begin
            sel = glmd_pkg::SLOT_ABOVE_LEFT;
        end else if (remaining[1]) begin
            sel = glmd_pkg::SLOT_ABOVE;
        end else if (remaining[2]) begin
            sel = glmd_pkg::SLOT_LEFT;
        end else begin
            sel = glmd_pkg::SLOT_CENTER;
        end
    end

    assign sel_bit   = glmd_pkg::NUM_SLOTS'(1) << sel;
    assign dr_sel    = sel[1];
    assign dc_sel    = sel[0];
    assign top_excl  = dr_sel ? (stage_i.row == '0) : (stage_i.row == glmd_pkg::ROW_BITS'(1));
    assign left_excl = dc_sel ? (stage_i.col == '0) : (stage_i.col == glmd_pkg::COL_BITS'(1));
    assign res_row   = dr_sel ? stage_i.row : stage_i.row - glmd_pkg::ROW_BITS'(1);
    assign res_col   = dc_sel ? stage_i.col : stage_i.col - glmd_pkg::COL_BITS'(1);
    assign is_min    = glmd_pkg::decide_min(win_i, dr_sel, dc_sel, top_excl, left_excl);

    always_comb begin
        done_next = done_reg;
        if (release_o) begin
            done_next = '0;
        end else if (push) begin
            done_next = done_reg | sel_bit;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (push) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_data_reg <= {(glmd_pkg::OUT_TDATA_BITS - glmd_pkg::OUT_FIELD_BITS)'(0), is_min,
                           glmd_pkg::OUT_COL_BITS'(res_col), glmd_pkg::OUT_ROW_BITS'(res_row)};
            m_last_reg <= single;
            m_user_reg <= (sel == glmd_pkg::SLOT_CENTER);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

`ifndef ASSERT_OFF
    a_done_subset: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_i.valid |-> ((done_reg & ~stage_i.mask) == '0))
        else $error("emitted slot outside the pending mask");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !stage_i.valid |-> (done_reg == '0))
        else $error("slot progress left over with empty stage");

    a_hold_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !single) |=> (stage_i.valid && m_tvalid))
        else $error("stage dropped with decisions still pending");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("matrix end not on the last word of its cell");
`endif

endmodule

// File: dv/grid_local_minimum_detector_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for grid_local_minimum_detector_unit: streams distance grids,
// predicts each 3x3 local-minimum decision and checks the result words. Uses glmd_pkg.
module grid_local_minimum_detector_unit_tb;

    // register indexes the block has no register behind; writes there must be ignored
    localparam logic [glmd_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [glmd_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;
    localparam int RANDOM_CELLS  = 110;
    localparam int LARGE_CELLS   = 16;
    localparam int SETTLE_CYCLES = 10;

    typedef struct packed {
        logic [glmd_pkg::OUT_ROW_BITS-1:0] row;
        logic [glmd_pkg::OUT_COL_BITS-1:0] col;
        logic                              is_min;
        logic                              run_last;
        logic                              done;
    } decision_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    logic [glmd_pkg::CFG_INDEX_BITS-1:0] cfg_wr_index = '0;
    logic [glmd_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data = '0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [glmd_pkg::VALUE_BITS-1:0]     s_tdata = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [glmd_pkg::OUT_TDATA_BITS-1:0] m_tdata;
    logic                                m_tlast;
    logic                                m_tuser;

    grid_local_minimum_detector_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Prediction state: raw register values, effective grid size, the
    // raster position of the next cell and the last three rows seen.
    // ---------------------------------------------------------------
    logic [glmd_pkg::CFG_DATA_BITS-1:0] width_reg = glmd_pkg::CFG_DATA_BITS'(1024);
    logic [glmd_pkg::CFG_DATA_BITS-1:0] height_reg = glmd_pkg::CFG_DATA_BITS'(1024);
    int                                 grid_w = 1024;
    int                                 grid_h = 1024;
    int                                 next_row = 0;
    int                                 next_col = 0;
    glmd_pkg::val_t                     recent_rows [3][glmd_pkg::MAX_COLS];  // row mod 3

    decision_t pending_decisions[$];

    int  error_count = 0;
    int  cells_sent = 0;
    int  decisions_checked = 0;
    int  minima_seen = 0;
    int  settings_used = 0;
    bit  src_steady = 1'b0;
    bit  sink_steady = 1'b0;

    // register value 0 behaves as 1, anything past the store size is clamped
    function automatic int clamp_dim(input logic [glmd_pkg::CFG_DATA_BITS-1:0] v,
                                     input int limit);
        if (v == 0) return 1;
        return (int'(v) > limit) ? limit : int'(v);
    endfunction

    // center must be non-negative and <= every neighbor inside the grid
    function automatic logic is_local_min(input int r, input int c);
        glmd_pkg::val_t center;
        int             nr;
        int             nc;
        center = recent_rows[r % 3][c];
        if (center < 0) return 1'b0;
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                nr = r + dy;
                nc = c + dx;
                if ((dy == 0 && dx == 0) || nr < 0 || nr >= grid_h || nc < 0 || nc >= grid_w)
                    continue;
                if (center > recent_rows[nr % 3][nc]) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void queue_decision(input int r, input int c);
        decision_t d;
        d.row      = glmd_pkg::OUT_ROW_BITS'(r);
        d.col      = glmd_pkg::OUT_COL_BITS'(c);
        d.is_min   = is_local_min(r, c);
        d.run_last = 1'b0;
        d.done     = (r == grid_h - 1) && (c == grid_w - 1);
        pending_decisions.insert(pending_decisions.size(), d);
    endfunction

    // a cell completes the neighborhoods of up to four cells, in raster order
    function automatic void predict_decisions(input glmd_pkg::val_t v);
        int r;
        int c;
        int queued_at_start;
        bit last_col;
        bit last_row;
        r        = next_row;
        c        = next_col;
        last_col = (c == grid_w - 1);
        last_row = (r == grid_h - 1);
        queued_at_start = pending_decisions.size();
        recent_rows[r % 3][c] = v;
        if (r >= 1 && c >= 1) queue_decision(r - 1, c - 1);
        if (r >= 1 && last_col) queue_decision(r - 1, c);
        if (last_row && c >= 1) queue_decision(r, c - 1);
        if (last_row && last_col) queue_decision(r, c);
        if (pending_decisions.size() > queued_at_start) begin
            pending_decisions[pending_decisions.size() - 1].run_last = 1'b1;
        end
        if (last_col) begin
            next_col = 0;
            next_row = last_row ? 0 : r + 1;
        end else begin
            next_col = c + 1;
        end
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    function automatic int draw_gap(inout bit steady);
        if ($urandom_range(0, 19) == 0) steady = !steady;
        return steady ? 0 : int'($urandom_range(0, 9));
    endfunction

    // valid stays up across back-to-back words; only lowered when a gap is drawn
    task automatic send_cell(input glmd_pkg::val_t v);
        int gap;
        gap = draw_gap(src_steady);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        predict_decisions(v);
        cells_sent++;
    endtask

    // drop valid, let every expected word come out, then give the pipe time to empty
    task automatic wait_until_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [glmd_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [glmd_pkg::CFG_DATA_BITS-1:0] data);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        // model side: known registers update and restart the raster, others do nothing
        if (idx == glmd_pkg::REG_GRID_WIDTH) begin
            width_reg = data;
        end else if (idx == glmd_pkg::REG_GRID_HEIGHT) begin
            height_reg = data;
        end else begin
            return;
        end
        grid_w   = clamp_dim(width_reg, glmd_pkg::MAX_COLS);
        grid_h   = clamp_dim(height_reg, glmd_pkg::MAX_ROWS);
        next_row = 0;
        next_col = 0;
        settings_used++;
    endtask

    task automatic set_grid(input int w, input int h);
        write_reg(glmd_pkg::REG_GRID_WIDTH, glmd_pkg::CFG_DATA_BITS'(w));
        write_reg(glmd_pkg::REG_GRID_HEIGHT, glmd_pkg::CFG_DATA_BITS'(h));
    endtask

    // mostly small values so ties and minima are common; some negatives and full range
    function automatic glmd_pkg::val_t random_cell_value();
        case ($urandom_range(0, 9))
            6:       return -glmd_pkg::val_t'($urandom_range(1, 4));
            7:       return glmd_pkg::val_t'($urandom);
            8:       return glmd_pkg::val_t'($urandom & 32'h7FFF_FFFF);
            9: begin
                case ($urandom_range(0, 3))
                    0:       return glmd_pkg::val_t'(32'h8000_0000);
                    1:       return glmd_pkg::val_t'(32'h7FFF_FFFF);
                    2:       return glmd_pkg::val_t'(32'hFFFF_FFFF);
                    default: return glmd_pkg::val_t'(0);
                endcase
            end
            default: return glmd_pkg::val_t'($urandom_range(0, 7));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Result side: random backpressure plus the field-by-field check
    // ---------------------------------------------------------------
    always begin : result_sink
        int gap;
        @(negedge aclk);
        gap = draw_gap(sink_steady);
        if (gap > 0) begin
            m_tready <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        m_tready <= 1'b1;
        do @(posedge aclk); while (!m_tvalid);
    end

    function automatic void check_field(input string name, input decision_t want,
                                        input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s wrong for cell (%0d,%0d): expected %0h, got %0h",
                     $time, name, want.row, want.col, exp_val, act_val);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin : decision_checker
        decision_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_decisions.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %0h last=%0b done=%0b",
                         $time, m_tdata, m_tlast, m_tuser);
                error_count++;
            end else begin
                want = pending_decisions.pop_front();
                check_field("cell_row", want, int'(want.row), int'(m_tdata[9:0]));
                check_field("cell_col", want, int'(want.col), int'(m_tdata[19:10]));
                check_field("is_minimum", want, int'(want.is_min), int'(m_tdata[20]));
                check_field("run_last", want, int'(want.run_last), int'(m_tlast));
                check_field("matrix_done", want, int'(want.done), int'(m_tuser));
                decisions_checked++;
                if (want.is_min) minima_seen++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // reset size is 1024x1024, so a few row-0 cells give no decision yet
    task automatic test_reset_size();
        repeat (4) send_cell(random_cell_value());
        wait_until_quiet();
    endtask

    // extremes of the value range, negative neighbors, ties, back-to-back grids
    task automatic test_directed_grids();
        set_grid(3, 3);
        send_cell(glmd_pkg::val_t'(32'h7FFF_FFFF));
        send_cell(glmd_pkg::val_t'(0));
        send_cell(glmd_pkg::val_t'(32'h8000_0000));
        send_cell(glmd_pkg::val_t'(3));
        send_cell(glmd_pkg::val_t'(3));
        send_cell(glmd_pkg::val_t'(32'hFFFF_FFFF));
        send_cell(glmd_pkg::val_t'(0));
        send_cell(glmd_pkg::val_t'(3));
        send_cell(glmd_pkg::val_t'(32'h7FFF_FFFF));
        wait_until_quiet();
        // all-equal 2x2: every cell ties, every cell is a minimum
        set_grid(2, 2);
        repeat (4) send_cell(glmd_pkg::val_t'(5));
        wait_until_quiet();
    endtask

    // zero sizes behave as one: each cell is a whole grid
    task automatic test_single_cell();
        set_grid(0, 0);
        send_cell(glmd_pkg::val_t'(0));
        send_cell(glmd_pkg::val_t'(32'hFFFF_FFFF));
        wait_until_quiet();
    endtask

    // writes to unused indexes mid-grid must not restart the raster
    task automatic test_unused_index();
        set_grid(3, 2);
        repeat (3) send_cell(random_cell_value());
        wait_until_quiet();
        write_reg(REG_SPARE_LO, glmd_pkg::CFG_DATA_BITS'($urandom));
        write_reg(REG_SPARE_HI, glmd_pkg::CFG_DATA_BITS'($urandom));
        repeat (3) send_cell(random_cell_value());
        wait_until_quiet();
    endtask

    // small random grids, mostly complete, some cut short by a new setting
    task automatic test_random_grids();
        int budget;
        int cells;
        int n_send;
        budget = 0;
        while (budget < RANDOM_CELLS) begin
            case ($urandom_range(0, 3))
                0: write_reg(glmd_pkg::REG_GRID_WIDTH,
                             glmd_pkg::CFG_DATA_BITS'($urandom_range(0, 7)));
                1: write_reg(glmd_pkg::REG_GRID_HEIGHT,
                             glmd_pkg::CFG_DATA_BITS'($urandom_range(0, 5)));
                default: set_grid($urandom_range(0, 7), $urandom_range(0, 5));
            endcase
            cells = grid_w * grid_h;
            if ($urandom_range(0, 4) == 0)
                n_send = $urandom_range(1, cells);
            else
                n_send = cells * $urandom_range(1, 2);
            repeat (n_send) begin
                send_cell(random_cell_value());
                budget++;
            end
            wait_until_quiet();
        end
    endtask

    // oversize register values clamp to the full store: the start of one
    // full-width row, then the start of one full-height column
    task automatic test_largest_sizes();
        set_grid(2047, 1);
        repeat (LARGE_CELLS) send_cell(random_cell_value());
        wait_until_quiet();
        set_grid(1, 2047);
        repeat (LARGE_CELLS) send_cell(random_cell_value());
        wait_until_quiet();
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_size();
        test_directed_grids();
        test_single_cell();
        test_unused_index();
        test_random_grids();
        test_largest_sizes();
        $display("Streamed %0d cells over %0d size writes, small grids plus clamped sizes.",
                 cells_sent, settings_used);
        $display("Checked %0d decisions, %0d of them local minima.",
                 decisions_checked, minima_seen);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #5ms;
        $display("Timed out with %0d decisions outstanding.", pending_decisions.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
